>>> hw/rtl/lkvc_pkg.sv
// Shared sizes, codes and types of the LRU key-value cache.
package lkvc_pkg;

  // Storage geometry.
  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 64;

  // Fixed field widths of the stream payloads and the capacity register.
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CAP_W   = 5;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CAP_W > OCC_W) ? CAP_W : OCC_W;

  localparam int unsigned S_TDATA_W = ((KEY_W + VALUE_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((VALUE_W + KEY_W + 7) / 8) * 8;
  localparam int unsigned M_TUSER_W = 2;

  // Bit positions inside the result tuser.
  localparam int unsigned TUSER_HIT   = 0;
  localparam int unsigned TUSER_EVICT = 1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_AGE,
    ST_AGE_END,
    ST_WRITE,
    ST_DONE
  } state_e;

  // Outcome of one pass over the stored entries.
  typedef struct packed {
    logic                found;
    logic [IDX_W-1:0]    found_idx;
    logic [IDX_W-1:0]    found_rank;
    logic                have_lru;
    logic [IDX_W-1:0]    lru_idx;
    logic [IDX_W-1:0]    lru_rank;
    logic [KEY_BITS-1:0] lru_key;
  } scan_res_t;

endpackage

>>> hw/rtl/lru_key_value_cache_core.sv
// Top level of the LRU key-value cache: control sequencer, stores and result register.
// The result beat follows two passes over the single read port of the rank memory: one
// pass scans keys and ranks, the second ages the ranks by read-modify-write before the final
// write. A get that misses skips the aging pass. The core works on one beat at a time and
// takes the next beat only after the previous result has been loaded into the result register;
// a new beat is taken while a result waits. Reset clears valid bits, occupancy and control;
// capacity resets to 16.
module lru_key_value_cache_core import lkvc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Capacity register write.
  input  logic                 cfg_we_i,
  input  logic [CAP_W-1:0]     cfg_wdata_i,
  // Request stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // key [31:0], value [95:32]
  input  logic                 s_axis_tuser,   // opcode [0]
  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // read_value [63:0], evicted_key [95:64]
  output logic [M_TUSER_W-1:0] m_axis_tuser    // hit [0], evicted [1]
);

  state_e state_q, state_d;

  logic [IDX_W-1:0]      cnt_q, cnt_d;
  logic [CAP_W-1:0]      cap_q;
  logic [OCC_W-1:0]      occ_q;
  logic [ENTRIES-1:0]    valid_q;

  opcode_e               op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  // Registered index and valid that follow each memory read during the two passes.
  logic                  rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]      rd_idx_q;

  // Decision taken once the scan has finished.
  logic                  hit_q, evict_q, insert_q, update_q;
  logic [IDX_W-1:0]      target_q;
  logic [IDX_W-1:0]      old_rank_q;
  logic                  old_inf_q;
  logic [KEY_BITS-1:0]   evk_q;

  // Result register that parts the sequencer from the output stream.
  logic                  m_valid_q;
  logic [M_TDATA_W-1:0]  m_data_q;
  logic [M_TUSER_W-1:0]  m_user_q;

  logic                  in_beat;
  logic                  last_cnt;
  logic                  load_out;

  logic                  key_re, rank_re, data_re;
  logic                  rank_we, age_we;
  logic [IDX_W-1:0]      rank_waddr;
  logic [IDX_W-1:0]      rank_wdata;
  logic                  put_write;

  logic [KEY_BITS-1:0]   key_rdata;
  logic [IDX_W-1:0]      rank_rdata;
  logic [VALUE_BITS-1:0] data_rdata;

  logic                  scan_vld;
  scan_res_t             scan_res;

  logic [CMP_W-1:0]      cap_eff;
  logic                  full;
  logic [IDX_W-1:0]      free_idx;

  logic [VALUE_BITS-1:0] rd_value;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign last_cnt = (cnt_q == IDX_W'(ENTRIES - 1));
  assign load_out = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  // ---------------------------------------------------------------------------
  // Sequencer: scan pass, decision, aging pass, final write, result hand-off.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_beat) state_d = ST_SCAN;
      ST_SCAN:     if (last_cnt) state_d = ST_SCAN_END;
      ST_SCAN_END: state_d = ST_DECIDE;
      ST_DECIDE: begin
        // A get that misses changes nothing and goes straight to the result.
        if (scan_res.found || (op_q == OP_PUT)) begin
          state_d = ST_AGE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_AGE:      if (last_cnt) state_d = ST_AGE_END;
      ST_AGE_END:  state_d = ST_WRITE;
      ST_WRITE:    state_d = ST_DONE;
      ST_DONE:     if (load_out) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    key_re        = 1'b0;
    rank_re       = 1'b0;
    data_re       = 1'b0;
    rd_vld_d      = 1'b0;
    put_write     = 1'b0;
    cnt_d         = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cnt_d         = '0;
      end
      ST_SCAN: begin
        key_re   = 1'b1;
        rank_re  = 1'b1;
        rd_vld_d = 1'b1;
        cnt_d    = cnt_q + 1'b1;
      end
      ST_DECIDE: begin
        // Fetch the stored word now; only a get hit uses it.
        data_re = 1'b1;
        cnt_d   = '0;
      end
      ST_AGE: begin
        rank_re  = 1'b1;
        rd_vld_d = 1'b1;
        cnt_d    = cnt_q + 1'b1;
      end
      ST_WRITE: begin
        put_write = (op_q == OP_PUT);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stores. Keys, data words and recency ranks live in three RAMs; valid bits
  // are flip-flops so that reset empties the cache at once. Accesses never
  // overlap on one entry: the aging pass writes entry i-1 while it reads entry
  // i, and the final write to the target comes after the pass has drained.
  // ---------------------------------------------------------------------------
  assign scan_vld = rd_vld_q && ((state_q == ST_SCAN) || (state_q == ST_SCAN_END));

  // During aging, every valid entry other than the target that was more recent
  // than the target moves one rank older. A fresh slot counts as older than all.
  assign age_we = rd_vld_q && ((state_q == ST_AGE) || (state_q == ST_AGE_END)) &&
                  valid_q[rd_idx_q] && (rd_idx_q != target_q) &&
                  (old_inf_q || (rank_rdata < old_rank_q));

  assign rank_we    = age_we || (state_q == ST_WRITE);
  assign rank_waddr = (state_q == ST_WRITE) ? target_q : rd_idx_q;
  assign rank_wdata = (state_q == ST_WRITE) ? '0 : rank_rdata + 1'b1;

  lkvc_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (put_write),
    .waddr_i (target_q),
    .wdata_i (key_q),
    .re_i    (key_re),
    .raddr_i (cnt_q),
    .rdata_o (key_rdata)
  );

  lkvc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (ENTRIES)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rank_waddr),
    .wdata_i (rank_wdata),
    .re_i    (rank_re),
    .raddr_i (cnt_q),
    .rdata_o (rank_rdata)
  );

  lkvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (put_write),
    .waddr_i (target_q),
    .wdata_i (value_q),
    .re_i    (data_re),
    .raddr_i (scan_res.found_idx),
    .rdata_o (data_rdata)
  );

  lkvc_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_i        (in_beat),
    .vld_i        (scan_vld),
    .idx_i        (rd_idx_q),
    .ent_valid_i  (valid_q[rd_idx_q]),
    .key_i        (key_rdata),
    .rank_i       (rank_rdata),
    .search_key_i (key_q),
    .res_o        (scan_res)
  );

  // ---------------------------------------------------------------------------
  // Decision: effective capacity, occupancy check and the lowest free slot.
  // A capacity of zero acts as one; a capacity above the entry count is clipped.
  // ---------------------------------------------------------------------------
  always_comb begin
    cap_eff = CMP_W'(cap_q);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_eff > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end
  end

  assign full = (CMP_W'(occ_q) >= cap_eff);

  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign rd_value = ((op_q == OP_GET) && hit_q) ? data_rdata : '0;

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      cap_q    <= CAP_RESET;
      occ_q    <= '0;
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      evict_q  <= 1'b0;
      insert_q <= 1'b0;
      update_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;

      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end

      if (state_q == ST_DECIDE) begin
        hit_q    <= scan_res.found;
        evict_q  <= 1'b0;
        insert_q <= 1'b0;
        update_q <= scan_res.found || (op_q == OP_PUT);
        if (!scan_res.found && (op_q == OP_PUT)) begin
          if (full) begin
            evict_q <= 1'b1;
          end else begin
            insert_q <= 1'b1;
          end
        end
      end

      if ((state_q == ST_WRITE) && update_q) begin
        valid_q[target_q] <= 1'b1;
        if (insert_q) begin
          occ_q <= occ_q + 1'b1;
        end
      end

      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (in_beat) begin
      op_q    <= opcode_e'(s_axis_tuser);
      key_q   <= s_axis_tdata[KEY_BITS-1:0];
      value_q <= s_axis_tdata[KEY_W +: VALUE_BITS];
    end
    if (state_q == ST_DECIDE) begin
      evk_q     <= '0;
      old_inf_q <= 1'b0;
      if (scan_res.found) begin
        target_q   <= scan_res.found_idx;
        old_rank_q <= scan_res.found_rank;
      end else if (full && (op_q == OP_PUT)) begin
        // The least recent entry is reused in place; entries more recent than its old rank age by one.
        target_q   <= scan_res.lru_idx;
        old_rank_q <= scan_res.lru_rank;
        evk_q      <= scan_res.lru_key;
      end else begin
        target_q   <= free_idx;
        old_rank_q <= '0;
        old_inf_q  <= 1'b1;
      end
    end
    if (load_out) begin
      m_data_q <= M_TDATA_W'({KEY_W'(evk_q), VALUE_W'(rd_value)});
      m_user_q <= M_TUSER_W'({evict_q, hit_q});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy does not match the number of valid entries");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= ENTRIES)
    else $error("occupancy above entry count");

  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[TUSER_EVICT] |-> !m_axis_tuser[TUSER_HIT])
    else $error("eviction reported together with a hit");

  a_insert_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) && insert_q |-> !valid_q[target_q])
    else $error("new entry placed over a valid slot");

  a_beat_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == ST_SCAN) && (cnt_q == '0))
    else $error("accepted beat did not start a scan");

endmodule

>>> hw/rtl/lkvc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module lkvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/lkvc_scan.sv
// Scan unit: finds the matching key and the least recent entry over streamed reads.
module lkvc_scan import lkvc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clr_i,
  input  logic                vld_i,
  input  logic [IDX_W-1:0]    idx_i,
  input  logic                ent_valid_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [IDX_W-1:0]    rank_i,
  input  logic [KEY_BITS-1:0] search_key_i,
  output scan_res_t           res_o
);

  scan_res_t res_q, res_d;

  always_comb begin
    res_d = res_q;
    if (clr_i) begin
      res_d.found    = 1'b0;
      res_d.have_lru = 1'b0;
    end else if (vld_i && ent_valid_i) begin
      // The lowest matching slot wins; ranks are distinct, so the last
      // maximum seen is the least recent entry.
      if (!res_q.found && (key_i == search_key_i)) begin
        res_d.found      = 1'b1;
        res_d.found_idx  = idx_i;
        res_d.found_rank = rank_i;
      end
      if (!res_q.have_lru || (rank_i >= res_q.lru_rank)) begin
        res_d.have_lru = 1'b1;
        res_d.lru_idx  = idx_i;
        res_d.lru_rank = rank_i;
        res_d.lru_key  = key_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

>>> tb/tb.sv
// Self-checking stream testbench for the LRU key-value cache core.
module tb;
  import lkvc_pkg::*;

  // Give up long after the slowest correct run would have finished.
  localparam longint unsigned RUN_LIMIT = 64'd12 * 64'd600000;
  localparam int unsigned POOL_SIZE = 24;

  // One request beat and one result beat, unpacked into their fields.
  typedef struct packed {
    opcode_e            op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } cache_req_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
  } cache_result_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CAP_W-1:0]     cfg_wdata_i  = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  always #6 clk_i = ~clk_i;

  lru_key_value_cache_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Requests waiting to be driven, and results owed by the block in order.
  cache_req_t    pending_reqs[$];
  cache_result_t expected_results[$];
  int unsigned   fail_count = 0;

  // Shadow copy of the cache contents, kept in step with accepted beats.
  logic [CAP_W-1:0]      shadow_cap = CAP_RESET;
  logic                  shadow_valid[ENTRIES];
  logic [KEY_BITS-1:0]   shadow_key[ENTRIES];
  logic [VALUE_BITS-1:0] shadow_data[ENTRIES];
  int unsigned           shadow_rank[ENTRIES];
  int unsigned           shadow_occupancy = 0;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_data[i]  = '0;
      shadow_rank[i]  = 0;
    end
  end

  // Make slot s the most recent. Valid entries that were younger than s age by one;
  // a slot that was not valid yet counts as older than everything.
  function automatic void promote_slot(int unsigned s);
    int unsigned prev_rank;
    prev_rank = shadow_valid[s] ? shadow_rank[s] : 32'hFFFF_FFFF;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      if (i != s && shadow_valid[i] && shadow_rank[i] < prev_rank) shadow_rank[i]++;
    end
    shadow_rank[s] = 0;
  endfunction

  // Apply one request to the shadow cache and return the result the block must give.
  function automatic cache_result_t predict_access(cache_req_t req);
    cache_result_t       res;
    int unsigned         eff_cap;
    int unsigned         found;
    int unsigned         slot;
    int unsigned         oldest;
    logic [KEY_BITS-1:0] k;
    res = '0;
    k = req.key[KEY_BITS-1:0];
    // A capacity of zero behaves as one, anything above the store size as the store size.
    if (shadow_cap == 0) eff_cap = 1;
    else if (shadow_cap > ENTRIES) eff_cap = ENTRIES;
    else eff_cap = shadow_cap;

    found = ENTRIES;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      if (found == ENTRIES && shadow_valid[i] && shadow_key[i] == k) found = i;
    end

    if (found < ENTRIES) begin
      res.hit = 1'b1;
      if (req.op == OP_GET) res.read_value = VALUE_W'(shadow_data[found]);
      else shadow_data[found] = req.value[VALUE_BITS-1:0];
      promote_slot(found);
    end else if (req.op == OP_PUT) begin
      slot = ENTRIES;
      // Full (or over a lowered capacity): the least recent entry gives up its slot.
      if (shadow_occupancy >= eff_cap) begin
        oldest = 0;
        for (int unsigned i = 0; i < ENTRIES; i++) begin
          if (shadow_valid[i] && (slot == ENTRIES || shadow_rank[i] >= oldest)) begin
            slot   = i;
            oldest = shadow_rank[i];
          end
        end
        if (slot < ENTRIES) begin
          res.evicted     = 1'b1;
          res.evicted_key = KEY_W'(shadow_key[slot]);
        end
      end
      // Otherwise the lowest free slot takes the new entry.
      if (slot == ENTRIES) begin
        for (int unsigned i = 0; i < ENTRIES; i++) begin
          if (slot == ENTRIES && !shadow_valid[i]) slot = i;
        end
      end
      if (slot < ENTRIES) begin
        promote_slot(slot);
        if (!shadow_valid[slot]) shadow_occupancy++;
        shadow_valid[slot] = 1'b1;
        shadow_key[slot]   = k;
        shadow_data[slot]  = req.value[VALUE_BITS-1:0];
      end
    end
    return res;
  endfunction

  // Request driver. Each beat is followed by a random gap; now and then the driver
  // switches into a burst mode with no gaps at all. The next valid is worked out first
  // so that tvalid gets a single assignment per edge.
  cache_req_t  drv_req;
  int unsigned drv_gap = 0;
  bit          drv_burst = 1'b0;
  logic        drv_valid_nxt;

  always @(posedge clk_i) begin
    drv_valid_nxt = s_axis_tvalid;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_access(drv_req));
        drv_valid_nxt = 1'b0;
        if ($urandom_range(0, 39) == 0) drv_burst = !drv_burst;
        drv_gap = drv_burst ? 0 : $urandom_range(0, 19);
      end
      if (!drv_valid_nxt) begin
        if (drv_gap != 0) begin
          drv_gap--;
        end else if (pending_reqs.size() != 0) begin
          drv_req = pending_reqs.pop_front();
          s_axis_tdata  <= {drv_req.value, drv_req.key};
          s_axis_tuser  <= drv_req.op;
          drv_valid_nxt = 1'b1;
        end
      end
    end
    s_axis_tvalid <= drv_valid_nxt;
  end

  // Result monitor. Every result beat is matched against the oldest expectation,
  // then the receiver stalls for a random number of cycles (or none in burst mode).
  cache_result_t mon_exp;
  int unsigned   mon_stall = 0;
  bit            mon_burst = 1'b0;
  logic          mon_ready_nxt;
  logic               got_hit;
  logic               got_evicted;
  logic [VALUE_W-1:0] got_value;
  logic [KEY_W-1:0]   got_evicted_key;

  always @(posedge clk_i) begin
    mon_ready_nxt = m_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_hit         = m_axis_tuser[TUSER_HIT];
        got_evicted     = m_axis_tuser[TUSER_EVICT];
        got_value       = m_axis_tdata[VALUE_W-1:0];
        got_evicted_key = m_axis_tdata[VALUE_W+KEY_W-1:VALUE_W];
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, hit %0b value %h evicted %0b key %h",
                   $time, got_hit, got_value, got_evicted, got_evicted_key);
          fail_count++;
        end else begin
          mon_exp = expected_results.pop_front();
          if (got_hit !== mon_exp.hit) begin
            $display("%0t: hit mismatch, expected %0b, actual %0b", $time, mon_exp.hit, got_hit);
            fail_count++;
          end
          if (got_value !== mon_exp.read_value) begin
            $display("%0t: read_value mismatch, expected %h, actual %h",
                     $time, mon_exp.read_value, got_value);
            fail_count++;
          end
          if (got_evicted !== mon_exp.evicted) begin
            $display("%0t: evicted mismatch, expected %0b, actual %0b",
                     $time, mon_exp.evicted, got_evicted);
            fail_count++;
          end
          if (got_evicted_key !== mon_exp.evicted_key) begin
            $display("%0t: evicted_key mismatch, expected %h, actual %h",
                     $time, mon_exp.evicted_key, got_evicted_key);
            fail_count++;
          end
        end
        mon_ready_nxt = 1'b0;
        if ($urandom_range(0, 39) == 0) mon_burst = !mon_burst;
        mon_stall = mon_burst ? 0 : $urandom_range(0, 19);
      end
      if (!mon_ready_nxt) begin
        if (mon_stall != 0) mon_stall--;
        else mon_ready_nxt = 1'b1;
      end
    end
    m_axis_tready <= mon_ready_nxt;
  end

  task automatic push_req(opcode_e op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
    cache_req_t req;
    req.op    = op;
    req.key   = key;
    req.value = value;
    pending_reqs.push_back(req);
  endtask

  // The block is idle once every request went out, every result came back and it
  // is ready for a new beat. Sampled on the falling edge, away from the drive edge.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0 ||
           !s_axis_tready);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    shadow_cap  = cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stimulus: a directed opening, then random phases under a series of capacities.
  initial begin
    logic [KEY_W-1:0]   key_pool[POOL_SIZE];
    logic [CAP_W-1:0]   phase_caps[10];
    logic [KEY_W-1:0]   k;
    logic [VALUE_W-1:0] v;
    int unsigned        pool_n;
    int unsigned        eff_cap;
    int unsigned        r;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset capacity: a miss on the empty store, the key and value extremes, an update.
    push_req(OP_GET, 32'h0000_0000, '0);
    push_req(OP_PUT, 32'h7FFF_FFFF, '1);
    push_req(OP_PUT, 32'h8000_0000, '0);
    push_req(OP_GET, 32'h7FFF_FFFF, '0);
    push_req(OP_GET, 32'h8000_0000, '1);
    push_req(OP_PUT, 32'h7FFF_FFFF, 64'h5555_5555_5555_5555);
    push_req(OP_GET, 32'h7FFF_FFFF, '0);
    push_req(OP_PUT, 32'h0000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
    push_req(OP_PUT, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF);
    push_req(OP_GET, 32'hFFFF_FFFF, '0);
    push_req(OP_GET, 32'h1234_5678, '0);
    wait_idle();

    // Capacity dropped below the occupancy: each new key now evicts one entry.
    write_capacity(CAP_W'(2));
    push_req(OP_PUT, 32'h0000_0001, 64'h1111_0000_1111_0000);
    push_req(OP_PUT, 32'h0000_0002, 64'h2222_0000_2222_0000);
    push_req(OP_GET, 32'h8000_0000, '0);
    push_req(OP_GET, 32'h0000_0001, '0);
    wait_idle();

    // Capacity zero behaves as one.
    write_capacity(CAP_W'(0));
    push_req(OP_PUT, 32'h0000_0003, 64'h3333_3333_3333_3333);
    push_req(OP_GET, 32'h0000_0001, '0);
    push_req(OP_PUT, 32'h0000_0002, 64'hFFFF_0000_FFFF_0000);
    wait_idle();

    // Capacity above the store size behaves as the store size; free slots fill again.
    write_capacity(CAP_W'(31));
    push_req(OP_PUT, 32'h0000_0004, 64'h4444_4444_4444_4444);
    push_req(OP_PUT, 32'h0000_0005, 64'h5555_5555_5555_5555);
    push_req(OP_GET, 32'h0000_0003, '0);
    wait_idle();

    // Random phases. Keys come mostly from a small pool a little larger than the
    // capacity, so hits, updates and evictions all happen often.
    phase_caps = '{CAP_W'(16), CAP_W'(1), CAP_W'(5), CAP_W'(0), CAP_W'(31),
                   CAP_W'(2), CAP_W'(8), CAP_W'(17), CAP_W'(15),
                   CAP_W'($urandom_range(0, 31))};
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    for (int p = 0; p < 10; p++) begin
      write_capacity(phase_caps[p]);
      if (phase_caps[p] == 0) eff_cap = 1;
      else if (phase_caps[p] > ENTRIES) eff_cap = ENTRIES;
      else eff_cap = phase_caps[p];
      pool_n = eff_cap + $urandom_range(1, 6);
      if (pool_n > POOL_SIZE) pool_n = POOL_SIZE;
      // Freshen part of the pool so that stored keys go stale over time.
      for (int j = 0; j < 4; j++) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;

      for (int n = 0; n < 145; n++) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          k = key_pool[$urandom_range(0, pool_n - 1)];
        end else if (r < 90) begin
          case ($urandom_range(0, 3))
            0: k = 32'h8000_0000;
            1: k = 32'h7FFF_FFFF;
            2: k = 32'hFFFF_FFFF;
            default: k = 32'h0000_0000;
          endcase
        end else begin
          k = $urandom;
        end
        case ($urandom_range(0, 15))
          0: v = '0;
          1: v = '1;
          default: v = {$urandom, $urandom};
        endcase
        push_req(opcode_e'($urandom_range(0, 1)), k, v);
      end
      wait_idle();
    end

    // Let a stray late beat show up before the verdict.
    repeat (2 * ENTRIES + 16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_ram.sv
hw/rtl/lkvc_scan.sv
hw/rtl/lru_key_value_cache_core.sv
tb/tb.sv
